// ===== rtl/core/next_fit_unit_pool_allocator_defines.svh =====
// Assertion macros for the unit pool allocator.
`ifndef NEXT_FIT_UNIT_POOL_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_UNIT_POOL_ALLOCATOR_DEFINES_SVH

`define NFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define NFA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/nfa_pkg.sv =====
package nfa_pkg;

  localparam int unsigned NumUnits   = 256;
  localparam int unsigned NumHandles = 16;
  localparam int unsigned UnitW      = $clog2(NumUnits);
  localparam int unsigned CntW       = UnitW + 1;
  localparam int unsigned HandleW    = $clog2(NumHandles);
  localparam int unsigned QCntW      = HandleW + 1;
  localparam logic [23:0] Max24      = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CmdAlloc   = 2'd0,
    CmdRelease = 2'd1,
    CmdClear   = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoHandle  = 3'd1,
    StExternal  = 3'd2,
    StBadHandle = 3'd3,
    StBadRange  = 3'd4,
    StZeroReq   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    FsmIdle,
    FsmDecode,
    FsmDivide,
    FsmScan,
    FsmMark,
    FsmMul,
    FsmRelChk,
    FsmRelUnmark,
    FsmClear,
    FsmFull,
    FsmResult
  } fsm_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic scan_start;
    logic scan_step;
    logic mark_start;
    logic mark_step;
    logic mark_val;
    logic mul_start;
    logic mul_step;
    logic commit_alloc;
    logic commit_ext;
    logic commit_release;
    logic commit_clear;
    logic full_start;
    logic full_step;
    logic clear_step;
    logic set_status;
    status_e status;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic    zero_req;
    logic    q_empty;
    logic    div_done;
    logic    scan_done;
    logic    scan_hit;
    logic    mark_done;
    logic    mul_done;
    logic    rel_bad_handle;
    logic    rel_ext;
    logic    rel_bad_range;
    logic    clear_done;
    logic    full_done;
    cmd_e    cmd;
  } stat_t;

endpackage

// ===== rtl/core/nfa_ctrl.sv =====
module nfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           out_free_i,
  input  nfa_pkg::stat_t stat_i,
  output nfa_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);

  nfa_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfa_pkg::FsmClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.status = nfa_pkg::StOk;
    busy_o = (state_q != nfa_pkg::FsmIdle);
    case (state_q)
      nfa_pkg::FsmIdle: begin
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          state_d = nfa_pkg::FsmDecode;
        end
      end
      nfa_pkg::FsmDecode: begin
        ctrl_o.set_status = 1'b1;
        case (stat_i.cmd)
          nfa_pkg::CmdAlloc: begin
            if (stat_i.zero_req) begin
              ctrl_o.status = nfa_pkg::StZeroReq;
              state_d = nfa_pkg::FsmResult;
            end else if (stat_i.q_empty) begin
              ctrl_o.status = nfa_pkg::StNoHandle;
              state_d = nfa_pkg::FsmResult;
            end else begin
              ctrl_o.div_start = 1'b1;
              state_d = nfa_pkg::FsmDivide;
            end
          end
          nfa_pkg::CmdRelease: begin
            state_d = nfa_pkg::FsmRelChk;
          end
          nfa_pkg::CmdClear: begin
            state_d = nfa_pkg::FsmClear;
          end
          default: begin
            state_d = nfa_pkg::FsmResult;
          end
        endcase
      end
      nfa_pkg::FsmDivide: begin
        if (stat_i.div_done) begin
          ctrl_o.scan_start = 1'b1;
          state_d = nfa_pkg::FsmScan;
        end
      end
      nfa_pkg::FsmScan: begin
        if (stat_i.scan_done) begin
          ctrl_o.set_status = 1'b1;
          if (stat_i.scan_hit) begin
            ctrl_o.status = nfa_pkg::StOk;
            ctrl_o.mark_start = 1'b1;
            ctrl_o.mark_val = 1'b1;
            state_d = nfa_pkg::FsmMark;
          end else begin
            ctrl_o.status = nfa_pkg::StExternal;
            ctrl_o.commit_ext = 1'b1;
            state_d = nfa_pkg::FsmResult;
          end
        end else begin
          ctrl_o.scan_step = 1'b1;
        end
      end
      nfa_pkg::FsmMark: begin
        ctrl_o.mark_val = 1'b1;
        if (stat_i.mark_done) begin
          ctrl_o.mul_start = 1'b1;
          state_d = nfa_pkg::FsmMul;
        end else begin
          ctrl_o.mark_step = 1'b1;
        end
      end
      nfa_pkg::FsmMul: begin
        if (stat_i.mul_done) begin
          ctrl_o.commit_alloc = 1'b1;
          state_d = nfa_pkg::FsmResult;
        end else begin
          ctrl_o.mul_step = 1'b1;
        end
      end
      nfa_pkg::FsmRelChk: begin
        ctrl_o.set_status = 1'b1;
        if (stat_i.rel_bad_handle) begin
          ctrl_o.status = nfa_pkg::StBadHandle;
          state_d = nfa_pkg::FsmResult;
        end else if (stat_i.rel_ext) begin
          ctrl_o.commit_release = 1'b1;
          state_d = nfa_pkg::FsmResult;
        end else if (stat_i.rel_bad_range) begin
          ctrl_o.status = nfa_pkg::StBadRange;
          state_d = nfa_pkg::FsmResult;
        end else begin
          ctrl_o.mark_start = 1'b1;
          ctrl_o.mul_start = 1'b1;
          state_d = nfa_pkg::FsmRelUnmark;
        end
      end
      nfa_pkg::FsmRelUnmark: begin
        if (stat_i.mark_done && stat_i.mul_done) begin
          ctrl_o.commit_release = 1'b1;
          state_d = nfa_pkg::FsmResult;
        end else begin
          ctrl_o.mark_step = !stat_i.mark_done;
          ctrl_o.mul_step = !stat_i.mul_done;
        end
      end
      nfa_pkg::FsmClear: begin
        if (stat_i.clear_done) begin
          ctrl_o.full_start = 1'b1;
          state_d = nfa_pkg::FsmFull;
        end else begin
          ctrl_o.clear_step = 1'b1;
        end
      end
      nfa_pkg::FsmFull: begin
        if (stat_i.full_done) begin
          ctrl_o.commit_clear = 1'b1;
          state_d = (stat_i.cmd == nfa_pkg::CmdClear) ? nfa_pkg::FsmResult
                                                       : nfa_pkg::FsmIdle;
        end else begin
          ctrl_o.full_step = 1'b1;
        end
      end
      nfa_pkg::FsmResult: begin
        if (out_free_i) begin
          ctrl_o.out_valid = 1'b1;
          state_d = nfa_pkg::FsmIdle;
        end
      end
      default: begin
        state_d = nfa_pkg::FsmIdle;
      end
    endcase
  end

endmodule

// ===== rtl/core/nfa_dp.sv =====
module nfa_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [15:0]                  unit_size_i,
  input  logic [8:0]                   unit_count_i,
  input  logic [1:0]                   cmd_i,
  input  logic [23:0]                  req_i,
  input  logic [nfa_pkg::HandleW-1:0]  hin_i,
  input  nfa_pkg::ctrl_t               ctrl_i,
  output nfa_pkg::stat_t               stat_o,
  output logic [2:0]                   status_o,
  output logic [3:0]                   handle_o,
  output logic [7:0]                   start_o,
  output logic [8:0]                   run_o,
  output logic [23:0]                  free_o
);

  localparam int unsigned UW = nfa_pkg::UnitW;
  localparam int unsigned CW = nfa_pkg::CntW;
  localparam int unsigned HW = nfa_pkg::HandleW;
  localparam int unsigned QW = nfa_pkg::QCntW;

  logic                  used_q [nfa_pkg::NumUnits];
  logic                  used_rd_q;
  logic [HW-1:0]         hq_q [nfa_pkg::NumHandles];
  logic [HW-1:0]         qhead_q, qtail_q;
  logic [QW-1:0]         qcnt_q;
  logic [UW-1:0]         dstart_q [nfa_pkg::NumHandles];
  logic [CW-1:0]         dunits_q [nfa_pkg::NumHandles];
  logic                  dalloc_q [nfa_pkg::NumHandles];
  logic                  dext_q [nfa_pkg::NumHandles];
  logic [CW-1:0]         rover_q;
  logic [23:0]           free_q;

  logic [1:0]            cmd_q;
  logic [23:0]           req_q;
  logic [HW-1:0]         hin_q;
  logic [15:0]           sz_q;
  logic [CW-1:0]         cnt_q;
  logic [2:0]            status_q;
  logic [HW-1:0]         hout_q;
  logic [UW-1:0]         sout_q;
  logic [CW-1:0]         rout_q;

  // Restoring divider: quotient in req_q, remainder in rem_q.
  logic [16:0]           rem_q;
  logic [4:0]            dcnt_q;
  logic                  dbusy_q;
  logic [24:0]           need_q;

  // Scan engine.
  logic [CW-1:0]         pos_q, lim_q, last_q;
  logic [CW-1:0]         pos_d;
  logic [24:0]           run_q;
  logic                  pass_q, sdone_q, shit_q;

  // Mark/unmark engine and shift-add multiplier.
  logic [CW-1:0]         mpos_q, mleft_q;
  logic [39:0]           acc_q;
  logic [CW-1:0]         mbits_q;
  logic [15:0]           mcand_q;
  logic [3:0]            mcnt_q;
  logic                  mbusy_q;
  logic [CW-1:0]         ccnt_q;
  logic                  fbusy_q;

  logic [15:0]           sz_eff;
  logic [CW-1:0]         cnt_eff;
  logic [16:0]           rem_sh;
  logic [17:0]           rem_try;
  logic [HW-1:0]         head_h;
  logic [UW-1:0]         r_start;
  logic [CW-1:0]         r_units;
  logic [CW:0]           r_end;
  logic [24:0]           sum;
  logic [23:0]           prod24;

  assign sz_eff  = (unit_size_i == '0) ? 16'd1 : unit_size_i;
  assign cnt_eff = (unit_count_i > 9'(nfa_pkg::NumUnits)) ? CW'(nfa_pkg::NumUnits)
                                                          : CW'(unit_count_i);
  assign rem_sh  = {rem_q[15:0], req_q[23]};
  assign rem_try = {1'b0, rem_sh} - {2'b0, sz_q};
  assign head_h  = hq_q[qhead_q];
  assign r_start = dstart_q[hin_q];
  assign r_units = dunits_q[hin_q];
  assign r_end   = {1'b0, CW'(r_start)} + {1'b0, r_units};
  assign prod24  = (acc_q[39:24] != '0) ? nfa_pkg::Max24 : acc_q[23:0];

  always_comb begin
    stat_o = '0;
    stat_o.cmd            = nfa_pkg::cmd_e'(cmd_q);
    stat_o.zero_req       = (req_q == '0);
    stat_o.q_empty        = (qcnt_q == '0);
    stat_o.div_done       = !dbusy_q;
    stat_o.scan_done      = sdone_q;
    stat_o.scan_hit       = shit_q;
    stat_o.mark_done      = (mleft_q == '0);
    stat_o.mul_done       = !mbusy_q;
    stat_o.rel_bad_handle = !dalloc_q[hin_q];
    stat_o.rel_ext        = dext_q[hin_q];
    stat_o.rel_bad_range  = ({1'b0, CW'(r_start)} >= {1'b0, cnt_q}) ||
                            (r_end > {1'b0, cnt_q});
    stat_o.clear_done     = (ccnt_q == CW'(nfa_pkg::NumUnits));
    stat_o.full_done      = !mbusy_q && fbusy_q;
  end

  // The map is read through a registered port, so the scan address is formed here ahead of the read.
  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.scan_start) begin
      pos_d = rover_q;
    end else if (ctrl_i.scan_step) begin
      if (pos_q >= lim_q) begin
        if (!pass_q) begin
          pos_d = '0;
        end
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < nfa_pkg::NumHandles; i++) begin
        hq_q[i]     <= HW'(i);
        dalloc_q[i] <= 1'b0;
        dext_q[i]   <= 1'b0;
        dstart_q[i] <= '0;
        dunits_q[i] <= '0;
      end
      qhead_q <= '0;
      qtail_q <= '0;
      qcnt_q  <= QW'(nfa_pkg::NumHandles);
      rover_q <= '0;
      free_q  <= '0;
      dbusy_q <= 1'b0;
      mbusy_q <= 1'b1;
      fbusy_q <= 1'b1;
      acc_q   <= '0;
      mbits_q <= CW'(256);
      mcand_q <= 16'd1;
      mcnt_q  <= '0;
      cmd_q   <= nfa_pkg::CmdNone;
      mleft_q <= '0;
      ccnt_q  <= '0;
      sdone_q <= 1'b0;
      sz_q    <= 16'd1;
      cnt_q   <= CW'(nfa_pkg::NumUnits);
    end else begin
      pos_q <= pos_d;
      if (ctrl_i.load) begin
        cmd_q  <= cmd_i;
        req_q  <= req_i;
        hin_q  <= hin_i;
        sz_q   <= sz_eff;
        cnt_q  <= cnt_eff;
        ccnt_q <= '0;
        hout_q <= '0;
        sout_q <= '0;
        rout_q <= '0;
      end
      if (ctrl_i.set_status) begin
        status_q <= ctrl_i.status;
      end
      if (ctrl_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
        rem_q   <= '0;
        hout_q  <= head_h;
        qhead_q <= qhead_q + 1'b1;
        qcnt_q  <= qcnt_q - 1'b1;
      end else if (dbusy_q) begin
        if (!rem_try[17]) begin
          rem_q <= rem_try[16:0];
          req_q <= {req_q[22:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          req_q <= {req_q[22:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == 5'd23) begin
          dbusy_q <= 1'b0;
        end
      end
      if (ctrl_i.scan_start) begin
        need_q  <= {1'b0, req_q} + ((rem_q != '0) ? 25'd1 : 25'd0);
        lim_q   <= cnt_q;
        pass_q  <= 1'b0;
        run_q   <= '0;
        sdone_q <= 1'b0;
        shit_q  <= 1'b0;
      end else if (ctrl_i.scan_step) begin
        if (pos_q >= lim_q) begin
          if (!pass_q) begin
            pass_q <= 1'b1;
            lim_q  <= (rover_q < cnt_q) ? rover_q : cnt_q;
            run_q  <= '0;
          end else begin
            sdone_q <= 1'b1;
          end
        end else if (!used_rd_q) begin
          if (run_q + 25'd1 >= need_q) begin
            sdone_q <= 1'b1;
            shit_q  <= 1'b1;
            last_q  <= pos_q;
          end
          run_q <= run_q + 25'd1;
        end else begin
          run_q <= '0;
        end
      end
      if (ctrl_i.mark_start) begin
        if (cmd_q == nfa_pkg::CmdAlloc) begin
          mpos_q  <= last_q + 1'b1 - CW'(need_q);
          mleft_q <= CW'(need_q);
        end else begin
          mpos_q  <= CW'(r_start);
          mleft_q <= r_units;
        end
      end else if (ctrl_i.mark_step) begin
        mpos_q  <= mpos_q + 1'b1;
        mleft_q <= mleft_q - 1'b1;
      end
      if (ctrl_i.mul_start || ctrl_i.full_start) begin
        mbusy_q <= 1'b1;
        acc_q   <= '0;
        mcnt_q  <= '0;
        mcand_q <= sz_q;
        fbusy_q <= ctrl_i.full_start;
        if (ctrl_i.full_start) begin
          mbits_q <= cnt_q;
        end else if (cmd_q == nfa_pkg::CmdAlloc) begin
          mbits_q <= CW'(need_q);
        end else begin
          mbits_q <= r_units;
        end
      end else if (mbusy_q) begin
        acc_q   <= (acc_q << 1) + (mbits_q[CW-1] ? {24'd0, mcand_q} : 40'd0);
        mbits_q <= mbits_q << 1;
        mcnt_q  <= mcnt_q + 1'b1;
        if (mcnt_q == 4'(CW - 1)) begin
          mbusy_q <= 1'b0;
        end
      end
      if (ctrl_i.clear_step) begin
        ccnt_q <= ccnt_q + 1'b1;
      end
      if (ctrl_i.commit_clear) begin
        free_q  <= prod24;
        rover_q <= '0;
        fbusy_q <= 1'b0;
        if (cmd_q != nfa_pkg::CmdClear) begin
          sz_q  <= sz_eff;
          cnt_q <= cnt_eff;
        end
      end
      if (ctrl_i.commit_alloc) begin
        rover_q          <= last_q + 1'b1;
        free_q           <= ({16'd0, free_q} <= acc_q) ? 24'd0
                                                       : free_q - acc_q[23:0];
        dstart_q[hout_q] <= mpos_q[UW-1:0] - UW'(need_q);
        dunits_q[hout_q] <= CW'(need_q);
        dalloc_q[hout_q] <= 1'b1;
        dext_q[hout_q]   <= 1'b0;
        sout_q           <= mpos_q[UW-1:0] - UW'(need_q);
        rout_q           <= CW'(need_q);
      end
      if (ctrl_i.commit_ext) begin
        dstart_q[hout_q] <= '0;
        dunits_q[hout_q] <= '0;
        dalloc_q[hout_q] <= 1'b1;
        dext_q[hout_q]   <= 1'b1;
      end
      if (ctrl_i.commit_release) begin
        if (!dext_q[hin_q]) begin
          sout_q <= r_start;
          rout_q <= r_units;
          free_q <= sum[24] ? nfa_pkg::Max24 : sum[23:0];
        end
        dstart_q[hin_q] <= '0;
        dunits_q[hin_q] <= '0;
        dalloc_q[hin_q] <= 1'b0;
        dext_q[hin_q]   <= 1'b0;
        if (qcnt_q < QW'(nfa_pkg::NumHandles)) begin
          hq_q[qtail_q] <= hin_q;
          qtail_q       <= qtail_q + 1'b1;
          qcnt_q        <= qcnt_q + 1'b1;
        end
      end
      if (ctrl_i.set_status && cmd_q == nfa_pkg::CmdRelease) begin
        hout_q <= hin_q;
      end
    end
  end

  assign sum = {1'b0, free_q} + ((acc_q[39:24] != '0) ? 25'h1FFFFFF : {1'b0, acc_q[23:0]});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mark_step) begin
      used_q[mpos_q[UW-1:0]] <= ctrl_i.mark_val;
    end else if (ctrl_i.clear_step) begin
      used_q[ccnt_q[UW-1:0]] <= 1'b0;
    end
    used_rd_q <= used_q[pos_d[UW-1:0]];
  end

  assign status_o = status_q;
  assign handle_o = 4'(hout_q);
  assign start_o  = 8'(sout_q);
  assign run_o    = 9'(rout_q);
  assign free_o   = free_q;

endmodule

// ===== rtl/core/next_fit_unit_pool_allocator.sv =====
// Next-fit unit pool allocator. Each word on s_axis is one command (allocate,
// release, clear, or the fourth code, which changes nothing) and yields exactly
// one result word on m_axis; the next word is taken only after that result
// has been placed in the output register. An allocate runs the bit-serial
// unit division, the scan of the map from the rover and then from unit zero,
// the marking of the found units and the byte multiply; a release unmarks the
// freed units while the byte multiply runs beside it; a clear walks all 256
// map bits. After reset the block clears the map and computes the full byte
// count before the first word is taken. Unit size and unit count are sampled
// when each word is accepted; the free byte count is reloaded from them only
// by a clear or a reset. The map has one write port, used by the mark and
// clear sequencers, and a registered read port used by the scan, one unit per
// cycle.
module next_fit_unit_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cmd[1:0], request_bytes[25:2], handle_in[29:26], zero fill.
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[2:0], handle_out[6:3], start_unit[14:7], run_units[23:15],
  // free_bytes[47:24].
  output logic [47:0] m_axis_tdata
);

  localparam logic CfgUnitSize  = 1'b0;
  localparam logic CfgUnitCount = 1'b1;

  logic [15:0]    unit_size_q;
  logic [8:0]     unit_count_q;
  logic           out_valid_q;
  logic           busy;
  logic           in_fire;
  nfa_pkg::ctrl_t ctrl;
  nfa_pkg::stat_t stat;
  logic [2:0]     status;
  logic [3:0]     handle;
  logic [7:0]     start;
  logic [8:0]     run;
  logic [23:0]    free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_size_q  <= 16'd1;
      unit_count_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUnitSize:  unit_size_q  <= cfg_data_i;
        CfgUnitCount: unit_count_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  nfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (!out_valid_q || m_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  nfa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .unit_size_i  (unit_size_q),
    .unit_count_i (unit_count_q),
    .cmd_i        (s_axis_tdata[1:0]),
    .req_i        (s_axis_tdata[25:2]),
    .hin_i        (s_axis_tdata[29:26]),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .status_o     (status),
    .handle_o     (handle),
    .start_o      (start),
    .run_o        (run),
    .free_o       (free)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_valid) begin
      m_axis_tdata <= {free, run, start, handle, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;

`include "next_fit_unit_pool_allocator_defines.svh"

  `NFA_ASSERT(a_no_accept_busy, !(in_fire && busy), "accepted a word while busy")
  `NFA_ASSERT_NEXT(a_load_busy, in_fire, busy, "not busy after accepting a word")
  `NFA_ASSERT(a_result_slot, !(ctrl.out_valid && out_valid_q && !m_axis_tready),
    "result overwrote a pending word")

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import nfa_pkg::*;

  typedef struct packed {
    logic [23:0] free_bytes;
    logic [8:0]  run_units;
    logic [7:0]  start_unit;
    logic [3:0]  handle_out;
    logic [2:0]  status;
  } alloc_result_t;

  // Golden copy of the allocator state, updated once per accepted command word.
  class pool_scoreboard;
    logic [15:0]   unit_size;
    logic [8:0]    unit_count;
    bit            used [NumUnits];
    int unsigned   rover;
    int unsigned   free_cnt;
    int unsigned   hq [NumHandles];
    int unsigned   q_head, q_tail, q_count;
    int unsigned   d_start [NumHandles];
    int unsigned   d_units [NumHandles];
    bit            d_alloc [NumHandles];
    bit            d_ext [NumHandles];
    alloc_result_t pending [$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   hits, misses, releases, clears;

    function int unsigned eff_size();
      return (unit_size == 0) ? 1 : unit_size;
    endfunction

    function int unsigned eff_count();
      return (unit_count > NumUnits) ? NumUnits : unit_count;
    endfunction

    function void clear_pool();
      longint unsigned p;
      foreach (used[i]) used[i] = 0;
      rover = 0;
      p = longint'(eff_count()) * eff_size();
      free_cnt = (p > 24'hFFFFFF) ? 24'hFFFFFF : int'(p);
    endfunction

    function void reset_state();
      unit_size  = 1;
      unit_count = 256;
      for (int i = 0; i < NumHandles; i++) begin
        hq[i] = i; d_start[i] = 0; d_units[i] = 0; d_alloc[i] = 0; d_ext[i] = 0;
      end
      q_head = 0; q_tail = 0; q_count = NumHandles;
      errors = 0; checked = 0;
      clear_pool();
    endfunction

    function bit scan_run(int unsigned lo, int unsigned hi, int unsigned need,
                          output int unsigned last);
      int unsigned run;
      run = 0;
      last = 0;
      for (int unsigned i = lo; i < hi; i++) begin
        if (!used[i]) begin
          run++;
          if (run >= need) begin
            last = i;
            return 1;
          end
        end else begin
          run = 0;
        end
      end
      return 0;
    endfunction

    function void push(status_e st, int unsigned h, int unsigned s, int unsigned r);
      alloc_result_t e;
      e.status = st; e.handle_out = h[3:0]; e.start_unit = s[7:0];
      e.run_units = r[8:0]; e.free_bytes = free_cnt[23:0];
      pending.push_back(e);
    endfunction

    function void note_command(logic [31:0] word);
      cmd_e        cmd;
      int unsigned req, hin, cnt, sz, h, need, last, lim, st;
      bit          hit;
      longint unsigned bytes, sum;
      cmd = cmd_e'(word[1:0]);
      req = word[25:2];
      hin = word[29:26];
      cnt = eff_count();
      sz  = eff_size();
      case (cmd)
        CmdAlloc: begin
          if (req == 0) begin
            push(StZeroReq, 0, 0, 0);
          end else if (q_count == 0) begin
            push(StNoHandle, 0, 0, 0);
          end else begin
            h = hq[q_head];
            q_head = (q_head + 1) % NumHandles;
            q_count--;
            need = req / sz + ((req % sz) != 0);
            lim = (rover < cnt) ? rover : cnt;
            hit = scan_run(rover, cnt, need, last);
            if (!hit) hit = scan_run(0, lim, need, last);
            if (hit) begin
              st = last + 1 - need;
              for (int unsigned i = 0; i < need; i++) used[(st + i) % NumUnits] = 1;
              rover = last + 1;
              bytes = longint'(need) * sz;
              free_cnt = (bytes >= free_cnt) ? 0 : free_cnt - int'(bytes);
              d_start[h] = st; d_units[h] = need; d_alloc[h] = 1; d_ext[h] = 0;
              hits++;
              push(StOk, h, st, need);
            end else begin
              d_start[h] = 0; d_units[h] = 0; d_alloc[h] = 1; d_ext[h] = 1;
              misses++;
              push(StExternal, h, 0, 0);
            end
          end
        end
        CmdRelease: begin
          if (!d_alloc[hin]) begin
            push(StBadHandle, hin, 0, 0);
          end else if (!d_ext[hin] &&
                       (d_start[hin] >= cnt || d_start[hin] + d_units[hin] > cnt)) begin
            push(StBadRange, hin, 0, 0);
          end else begin
            st = d_ext[hin] ? 0 : d_start[hin];
            need = d_ext[hin] ? 0 : d_units[hin];
            for (int unsigned i = 0; i < need; i++) used[(st + i) % NumUnits] = 0;
            sum = longint'(free_cnt) + longint'(need) * sz;
            free_cnt = (sum > 24'hFFFFFF) ? 24'hFFFFFF : int'(sum);
            d_start[hin] = 0; d_units[hin] = 0; d_alloc[hin] = 0; d_ext[hin] = 0;
            if (q_count < NumHandles) begin
              hq[q_tail] = hin;
              q_tail = (q_tail + 1) % NumHandles;
              q_count++;
            end
            releases++;
            push(StOk, hin, st, need);
          end
        end
        CmdClear: begin
          clear_pool();
          clears++;
          push(StOk, 0, 0, 0);
        end
        default: push(StOk, 0, 0, 0);
      endcase
    endfunction

    function void check_result(logic [47:0] word);
      alloc_result_t got, exp;
      got = word;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word %h", word);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: exp st=%0d h=%0d s=%0d n=%0d fb=%0d got st=%0d h=%0d s=%0d n=%0d fb=%0d",
                   exp.status, exp.handle_out, exp.start_unit, exp.run_units, exp.free_bytes,
                   got.status, got.handle_out, got.start_unit, got.run_units, got.free_bytes);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;

  pool_scoreboard sb;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 46;
  bit          hold_recv = 0;

  next_fit_unit_pool_allocator dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_command(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    if (!rst_ni || hold_recv) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The word stays valid after acceptance until the next idle cycle or word.
  task automatic send_word(cmd_e cmd, logic [23:0] req, logic [3:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, h, req, cmd};
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (900) @(negedge clk_i);
  endtask

  task automatic write_cfg(bit idx, logic [15:0] val);
    drain();
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx) sb.unit_count = val[8:0];
    else sb.unit_size = val;
  endtask

  task automatic random_word(int unsigned size_cap);
    int unsigned r;
    logic [23:0] req;
    r = $urandom_range(99);
    if (r < 50) begin
      req = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(size_cap));
      send_word(CmdAlloc, req, 4'($urandom));
    end else if (r < 92) begin
      send_word(CmdRelease, 24'($urandom), 4'($urandom));
    end else if (r < 97) begin
      send_word(CmdClear, 24'($urandom), 4'($urandom));
    end else begin
      send_word(CmdNone, 24'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    repeat (20) @(negedge clk_i);
    send_word(CmdClear, 0, 0);

    send_word(CmdAlloc, 0, 0);
    send_word(CmdAlloc, 24'hFFFFFF, 0);
    send_word(CmdAlloc, 1, 4'hF);
    send_word(CmdAlloc, 255, 0);
    send_word(CmdRelease, 0, 0);
    send_word(CmdRelease, 0, 0);
    send_word(CmdRelease, 0, 1);
    send_word(CmdRelease, 0, 4'hF);
    for (int i = 0; i < 17; i++) send_word(CmdAlloc, 24'($urandom_range(1, 8)), 0);
    send_word(CmdNone, 24'hFFFFFF, 4'hF);
    write_cfg(1, 8);
    send_word(CmdRelease, 0, 4'd3);
    send_word(CmdClear, 0, 0);
    write_cfg(0, 0);
    write_cfg(1, 0);
    send_word(CmdClear, 0, 0);
    send_word(CmdAlloc, 5, 0);
    write_cfg(0, 16'hFFFF);
    write_cfg(1, 9'h1FF);
    send_word(CmdClear, 0, 0);
    send_word(CmdAlloc, 24'hFFFFFF, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
      case (phase)
        0: begin write_cfg(0, 16'd1); write_cfg(1, 9'd64); end
        1: begin write_cfg(0, 16'd100); write_cfg(1, 9'd256); end
        default: begin write_cfg(0, 16'($urandom_range(1, 4000))); write_cfg(1, 9'd200); end
      endcase
      send_word(CmdClear, 0, 0);
      for (int i = 0; i < 330; i++) begin
        if (phase == 1 && i == 100) begin
          hold_recv = 1;
          fork
            begin repeat (3000) @(negedge clk_i); hold_recv = 0; end
          join_none
        end
        if (phase == 0 && i == 200) begin
          s_axis_tvalid <= 0;
          while (sb.pending.size() != 0) @(negedge clk_i);
        end
        random_word((phase == 0) ? 12 : 2000);
      end
    end

    drain();
    $display("Ran %0d results: %0d pool hits, %0d external grants, %0d releases, %0d clears.",
             sb.checked, sb.hits, sb.misses, sb.releases, sb.clears);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS next_fit_unit_pool_allocator");
    else $display("FAIL next_fit_unit_pool_allocator");
    $finish;
  end

  initial begin
    #50000000;
    $display("FAIL next_fit_unit_pool_allocator");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/nfa_pkg.sv
rtl/core/nfa_ctrl.sv
rtl/core/nfa_dp.sv
rtl/core/next_fit_unit_pool_allocator.sv
tb/testbench.sv
